### src/plt_pkg.sv
// Package for the piecewise-linear tone curve: sizes, register indexes,
// reset values, the stage-enable bundle and the knot extraction function.
// No dependencies.
`timescale 1ns / 1ps

package plt_pkg;

	localparam int KNOTS    = 6;
	localparam int KNOT_W   = 8;
	localparam int REG_W    = 48;
	localparam int NUM_REGS = 6;
	localparam int IDX_W    = 3;
	localparam int NUM_W    = 2 * (KNOT_W + 1);
	localparam int MAG_W    = 2 * KNOT_W;

	localparam logic [IDX_W-1:0] REG_RED_IN    = 3'd0;
	localparam logic [IDX_W-1:0] REG_RED_OUT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GREEN_IN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_GREEN_OUT = 3'd3;
	localparam logic [IDX_W-1:0] REG_BLUE_IN   = 3'd4;
	localparam logic [IDX_W-1:0] REG_BLUE_OUT  = 3'd5;

	localparam logic [REG_W-1:0] RST_RED_IN    = 48'd281387306204160;
	localparam logic [REG_W-1:0] RST_RED_OUT   = 48'd270436318930432;
	localparam logic [REG_W-1:0] RST_GREEN_IN  = 48'd281473876313088;
	localparam logic [REG_W-1:0] RST_GREEN_OUT = 48'd281474380612608;
	localparam logic [REG_W-1:0] RST_BLUE_IN   = 48'd281473795053568;
	localparam logic [REG_W-1:0] RST_BLUE_OUT  = 48'd281474247691264;

	// Load enables for the five pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// Knots with a negative index or with bits above the register read as zero.
	function automatic logic [KNOT_W-1:0] knot_byte(input logic [REG_W-1:0] r, input int k);
		logic [KNOT_W-1:0] b;
		b = '0;
		if (k >= 0 && (k + 1) * KNOT_W <= REG_W) begin
			b = r[k*KNOT_W +: KNOT_W];
		end
		return b;
	endfunction

endpackage

### src/plt_channel.sv
// One channel of the tone curve: knot search, slope multiply, bias,
// two radix-16 division stages and the final correction.
// Depends on plt_pkg.
`timescale 1ns / 1ps

module plt_channel (
	input  logic                              clk,
	input  plt_pkg::stage_en_t                en,
	input  logic [plt_pkg::KNOT_W-1:0]        value,
	input  logic [plt_pkg::REG_W-1:0]         knot_in,
	input  logic [plt_pkg::REG_W-1:0]         knot_out,
	output logic [plt_pkg::KNOT_W-1:0]        result
);

	localparam int W = plt_pkg::KNOT_W;
	localparam int HALF = W / 2;

	logic [W-1:0]                  y_s1, dx_s1, den_s1;
	logic signed [W:0]             dy_s1;
	logic [W-1:0]                  y_s2, den_s2;
	logic signed [plt_pkg::NUM_W-1:0] num_s2;
	logic [W-1:0]                  y_s3, den_s3;
	logic                          neg_s3;
	logic [plt_pkg::MAG_W-1:0]     rem_s3;
	logic [W-1:0]                  y_s4, den_s4;
	logic                          neg_s4;
	logic [plt_pkg::MAG_W-1:0]     rem_s4;
	logic [HALF-1:0]               qhi_s4;
	logic [W-1:0]                  res_s5;

	logic [W-1:0]                  y_c, dx_c, den_c;
	logic signed [W:0]             dy_c;
	logic [plt_pkg::NUM_W-1:0]     mag_wide_c;
	logic [plt_pkg::MAG_W-1:0]     rem_hi_c, rem_lo_c;
	logic [HALF-1:0]               qhi_c, qlo_c;
	logic [W-1:0]                  q_c;

	// First knot at or above the value; a match, the first knot or no knot
	// at all gives the knot output directly with a zero slope term.
	always_comb begin
		logic [W-1:0] xj, yj, x0, y0;
		y_c  = plt_pkg::knot_byte(knot_out, plt_pkg::KNOTS - 1);
		dy_c = '0;
		dx_c = '0;
		den_c = W'(1);
		for (int k = plt_pkg::KNOTS - 1; k >= 0; k--) begin
			xj = plt_pkg::knot_byte(knot_in, k);
			yj = plt_pkg::knot_byte(knot_out, k);
			x0 = plt_pkg::knot_byte(knot_in, k - 1);
			y0 = plt_pkg::knot_byte(knot_out, k - 1);
			if (xj >= value) begin
				y_c = yj;
				if (xj == value || k == 0) begin
					dy_c  = '0;
					dx_c  = '0;
					den_c = W'(1);
				end else begin
					dy_c  = $signed({1'b0, yj}) - $signed({1'b0, y0});
					dx_c  = xj - value;
					den_c = xj - x0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			y_s1   <= y_c;
			dy_s1  <= dy_c;
			dx_s1  <= dx_c;
			den_s1 <= den_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			y_s2   <= y_s1;
			den_s2 <= den_s1;
			num_s2 <= plt_pkg::NUM_W'(dy_s1) * plt_pkg::NUM_W'($signed({1'b0, dx_s1}));
		end
	end

	// A positive numerator is biased by den - 1 so that the floor division
	// below yields the ceiling; the quotient never exceeds eight bits.
	always_comb begin
		if (num_s2 < 0) begin
			mag_wide_c = plt_pkg::NUM_W'(-num_s2);
		end else begin
			mag_wide_c = plt_pkg::NUM_W'(num_s2) + plt_pkg::NUM_W'(den_s2)
				- plt_pkg::NUM_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			y_s3   <= y_s2;
			den_s3 <= den_s2;
			neg_s3 <= num_s2 < 0;
			rem_s3 <= mag_wide_c[plt_pkg::MAG_W-1:0];
		end
	end

	always_comb begin
		logic [plt_pkg::MAG_W-1:0] sub;
		rem_hi_c = rem_s3;
		qhi_c    = '0;
		for (int i = HALF - 1; i >= 0; i--) begin
			sub = plt_pkg::MAG_W'({den_s3, HALF'(0)}) << i;
			if (rem_hi_c >= sub) begin
				rem_hi_c = rem_hi_c - sub;
				qhi_c[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			y_s4   <= y_s3;
			den_s4 <= den_s3;
			neg_s4 <= neg_s3;
			rem_s4 <= rem_hi_c;
			qhi_s4 <= qhi_c;
		end
	end

	always_comb begin
		logic [plt_pkg::MAG_W-1:0] sub;
		rem_lo_c = rem_s4;
		qlo_c    = '0;
		for (int i = HALF - 1; i >= 0; i--) begin
			sub = plt_pkg::MAG_W'(den_s4) << i;
			if (rem_lo_c >= sub) begin
				rem_lo_c = rem_lo_c - sub;
				qlo_c[i] = 1'b1;
			end
		end
		q_c = {qhi_s4, qlo_c};
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			res_s5 <= neg_s4 ? (y_s4 + q_c) : (y_s4 - q_c);
		end
	end

	assign result = res_s5;

endmodule

### src/piecewise_linear_tone_curve.sv
// Top level of the RGB piecewise-linear tone curve: knot registers,
// pipeline valid and stall control, and three channel pipelines.
// Depends on plt_pkg and plt_channel.
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_stall   red_in, green_in, blue_in
// output    out_valid / out_stall red_out, green_out, blue_out
// config    wr_en                 wr_index, wr_data
//
// One item is accepted per cycle while in_stall is low; an item passes
// through one stage each for knot search, multiply, bias and two division
// halves with the final correction. Reset clears the valid bits and loads
// the knot registers with their default curves. A stall on the output holds
// the last stage; earlier stages keep advancing into empty slots, so a
// stall loses and repeats nothing.

module piecewise_linear_tone_curve (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [plt_pkg::KNOT_W-1:0]     red_in,
	input  logic [plt_pkg::KNOT_W-1:0]     green_in,
	input  logic [plt_pkg::KNOT_W-1:0]     blue_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [plt_pkg::KNOT_W-1:0]     red_out,
	output logic [plt_pkg::KNOT_W-1:0]     green_out,
	output logic [plt_pkg::KNOT_W-1:0]     blue_out,
	input  logic                           wr_en,
	input  logic [plt_pkg::IDX_W-1:0]      wr_index,
	input  logic [plt_pkg::REG_W-1:0]      wr_data
);

	logic [plt_pkg::REG_W-1:0] red_in_q, red_out_q, green_in_q, green_out_q;
	logic [plt_pkg::REG_W-1:0] blue_in_q, blue_out_q;
	logic                      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	plt_pkg::stage_en_t        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_in_q    <= plt_pkg::RST_RED_IN;
			red_out_q   <= plt_pkg::RST_RED_OUT;
			green_in_q  <= plt_pkg::RST_GREEN_IN;
			green_out_q <= plt_pkg::RST_GREEN_OUT;
			blue_in_q   <= plt_pkg::RST_BLUE_IN;
			blue_out_q  <= plt_pkg::RST_BLUE_OUT;
		end else if (wr_en) begin
			unique case (wr_index)
				plt_pkg::REG_RED_IN:    red_in_q    <= wr_data;
				plt_pkg::REG_RED_OUT:   red_out_q   <= wr_data;
				plt_pkg::REG_GREEN_IN:  green_in_q  <= wr_data;
				plt_pkg::REG_GREEN_OUT: green_out_q <= wr_data;
				plt_pkg::REG_BLUE_IN:   blue_in_q   <= wr_data;
				plt_pkg::REG_BLUE_OUT:  blue_out_q  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		en.s5 = !valid_s5 || !out_stall;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	assign in_stall  = !en.s1;
	assign out_valid = valid_s5;

	plt_channel u_red (
		.clk      (clk),
		.en       (en),
		.value    (red_in),
		.knot_in  (red_in_q),
		.knot_out (red_out_q),
		.result   (red_out)
	);

	plt_channel u_green (
		.clk      (clk),
		.en       (en),
		.value    (green_in),
		.knot_in  (green_in_q),
		.knot_out (green_out_q),
		.result   (green_out)
	);

	plt_channel u_blue (
		.clk      (clk),
		.en       (en),
		.value    (blue_in),
		.knot_in  (blue_in_q),
		.knot_out (blue_out_q),
		.result   (blue_out)
	);

endmodule
